// ===== sv/i2cmts_pkg.sv =====
// shared types and constants for the i2c master transaction sequencer
package i2cmts_pkg;

  localparam logic [7:0] MAX_LENGTH       = 8'd255;
  localparam logic [4:0] MAX_ATTEMPTS_RST = 5'd20;

  // bus engine status codes, low three bits masked off
  localparam logic [7:0] ST_MASK      = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_REP_START = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;

  // flag bits
  localparam int unsigned FLAG_READ  = 0;
  localparam int unsigned FLAG_TWO_B = 1;

  typedef enum logic [0:0] {
    REQ_START = 1'b0,
    REQ_EVENT = 1'b1
  } req_type_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_SLAW    = 4'd2,
    PH_ADDRHI  = 4'd3,
    PH_ADDRLO  = 4'd4,
    PH_RESTART = 4'd5,
    PH_SLAR    = 4'd6,
    PH_RX      = 4'd7,
    PH_TX      = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_START  = 3'd1,
    ACT_SEND   = 3'd2,
    ACT_RXACK  = 3'd3,
    ACT_RXNACK = 3'd4,
    ACT_STOP   = 3'd5
  } action_e;

  typedef struct packed {
    logic        req_type;
    logic        is_read;
    logic        two_byte_addr;
    logic [7:0]  dev_addr;
    logic [15:0] mem_addr;
    logic [7:0]  length;
    logic [7:0]  bus_status;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic       failed;
    logic [7:0] byte_count;
  } res_t;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  attempt_count;
    logic [7:0]  remaining;
    logic [7:0]  transferred;
    logic [7:0]  latched_device;
    logic [15:0] latched_address;
    logic [1:0]  latched_flags;
  } state_t;

endpackage

// ===== sv/i2cmts_req_if.sv =====
// request channel: start items and bus status events
interface i2cmts_req_if;
  logic               valid;
  logic               ready;
  i2cmts_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/i2cmts_res_if.sv =====
// result channel: bus action and transaction status
interface i2cmts_res_if;
  logic               valid;
  logic               ready;
  i2cmts_pkg::res_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/i2c_master_transaction_sequencer.sv =====
// i2c master register read/write sequencer top level
// path: an accepted item goes into the input register, then through the step logic
//   into the result register
// throughput: one item per cycle while the result register is not stalled; the step logic is a single registered pass
// reset: async active low; phase idle, counters and latches zero, max_attempts 20
// ready falls only when the input register is full and the result register stalls
module i2c_master_transaction_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  i2cmts_req_if.sink           req_i,
  i2cmts_res_if.source         res_o
);

  // input register
  logic               in_vld_q;
  i2cmts_pkg::req_t   in_q;
  // sequencer state and config
  i2cmts_pkg::state_t st_q, st_d;
  logic [4:0]         max_attempts_q;
  // result register
  logic               res_vld_q;
  i2cmts_pkg::res_t   res_q, res_d;

  logic adv;   // input register item moves into the result register
  logic take;  // new item accepted

  assign adv         = in_vld_q && (!res_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || adv;
  assign take        = req_i.valid && req_i.ready;

  i2cmts_step u_step (
    .max_attempts_i (max_attempts_q),
    .cur_i          (st_q),
    .item_i         (in_q),
    .nxt_o          (st_d),
    .res_o          (res_d)
  );

  // control and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      res_vld_q      <= 1'b0;
      max_attempts_q <= i2cmts_pkg::MAX_ATTEMPTS_RST;
      st_q           <= '{phase: i2cmts_pkg::PH_IDLE, default: '0};
    end else begin
      if (take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      // result stays until taken, new one replaces it in the same cycle
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        max_attempts_q <= cfg_wdata_i;
      end
      // state moves only when an item is actually consumed
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= req_i.data;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

endmodule

// ===== sv/i2cmts_step.sv =====
// next-state and result logic for one item
module i2cmts_step (
  input  logic [4:0]         max_attempts_i,
  input  i2cmts_pkg::state_t cur_i,
  input  i2cmts_pkg::req_t   item_i,
  output i2cmts_pkg::state_t nxt_o,
  output i2cmts_pkg::res_t   res_o
);

  logic [7:0]          st;
  logic                fin;
  logic                fin_ok;
  i2cmts_pkg::action_e act;
  logic [7:0]          tx;
  i2cmts_pkg::state_t  nxt;
  i2cmts_pkg::res_t    res;

  always_comb begin
    st     = item_i.bus_status & i2cmts_pkg::ST_MASK;
    nxt    = cur_i;
    fin    = 1'b0;
    fin_ok = 1'b0;
    act    = i2cmts_pkg::ACT_NONE;
    tx     = 8'd0;
    res    = '0;

    if (item_i.req_type == i2cmts_pkg::REQ_START) begin
      nxt.latched_flags   = {item_i.two_byte_addr, item_i.is_read};
      nxt.latched_device  = item_i.dev_addr;
      nxt.latched_address = item_i.mem_addr;
      nxt.remaining       = (item_i.length > i2cmts_pkg::MAX_LENGTH) ?
                            i2cmts_pkg::MAX_LENGTH : item_i.length;
      nxt.transferred     = 8'd0;
      nxt.attempt_count   = 5'd0;
      if (max_attempts_i == 5'd0) begin
        fin = 1'b1;
      end else begin
        nxt.attempt_count = 5'd1;
        act               = i2cmts_pkg::ACT_START;
        nxt.phase         = i2cmts_pkg::PH_START;
      end
    end else begin
      case (cur_i.phase)
        i2cmts_pkg::PH_START: begin
          if (st inside {i2cmts_pkg::ST_START, i2cmts_pkg::ST_REP_START}) begin
            act = i2cmts_pkg::ACT_SEND; tx = cur_i.latched_device;
            nxt.phase = i2cmts_pkg::PH_SLAW;
          end else if (st == i2cmts_pkg::ST_ARB_LOST) begin
            act = i2cmts_pkg::ACT_START; nxt.phase = i2cmts_pkg::PH_START;
          end else begin
            fin = 1'b1;
          end
        end
        i2cmts_pkg::PH_SLAW: begin
          if (st == i2cmts_pkg::ST_SLAW_ACK) begin
            act = i2cmts_pkg::ACT_SEND;
            if (cur_i.latched_flags[i2cmts_pkg::FLAG_TWO_B]) begin
              tx = cur_i.latched_address[15:8]; nxt.phase = i2cmts_pkg::PH_ADDRHI;
            end else begin
              tx = cur_i.latched_address[7:0]; nxt.phase = i2cmts_pkg::PH_ADDRLO;
            end
          end else if (st == i2cmts_pkg::ST_SLAW_NACK) begin
            if (cur_i.attempt_count >= max_attempts_i) begin
              fin = 1'b1;
            end else begin
              nxt.attempt_count = cur_i.attempt_count + 5'd1;
              act = i2cmts_pkg::ACT_START; nxt.phase = i2cmts_pkg::PH_START;
            end
          end else if (st == i2cmts_pkg::ST_ARB_LOST) begin
            act = i2cmts_pkg::ACT_START; nxt.phase = i2cmts_pkg::PH_START;
          end else begin
            fin = 1'b1; act = i2cmts_pkg::ACT_STOP;
          end
        end
        i2cmts_pkg::PH_ADDRHI, i2cmts_pkg::PH_ADDRLO: begin
          if (st == i2cmts_pkg::ST_DATA_ACK) begin
            if (cur_i.phase == i2cmts_pkg::PH_ADDRHI) begin
              act = i2cmts_pkg::ACT_SEND; tx = cur_i.latched_address[7:0];
              nxt.phase = i2cmts_pkg::PH_ADDRLO;
            end else if (cur_i.latched_flags[i2cmts_pkg::FLAG_READ]) begin
              act = i2cmts_pkg::ACT_START; nxt.phase = i2cmts_pkg::PH_RESTART;
            end else if (cur_i.remaining != 8'd0) begin
              act = i2cmts_pkg::ACT_SEND; tx = item_i.write_byte;
              nxt.phase = i2cmts_pkg::PH_TX;
            end else begin
              fin = 1'b1; fin_ok = 1'b1; act = i2cmts_pkg::ACT_STOP;
            end
          end else if (st == i2cmts_pkg::ST_DATA_NACK) begin
            fin = 1'b1; fin_ok = 1'b1; act = i2cmts_pkg::ACT_STOP;
          end else if (st == i2cmts_pkg::ST_ARB_LOST) begin
            act = i2cmts_pkg::ACT_START; nxt.phase = i2cmts_pkg::PH_START;
          end else begin
            fin = 1'b1; act = i2cmts_pkg::ACT_STOP;
          end
        end
        i2cmts_pkg::PH_RESTART: begin
          if (st inside {i2cmts_pkg::ST_START, i2cmts_pkg::ST_REP_START}) begin
            act = i2cmts_pkg::ACT_SEND; tx = cur_i.latched_device | 8'h01;
            nxt.phase = i2cmts_pkg::PH_SLAR;
          end else if (st == i2cmts_pkg::ST_ARB_LOST) begin
            act = i2cmts_pkg::ACT_START; nxt.phase = i2cmts_pkg::PH_START;
          end else begin
            fin = 1'b1; act = i2cmts_pkg::ACT_STOP;
          end
        end
        i2cmts_pkg::PH_SLAR: begin
          if (st == i2cmts_pkg::ST_SLAR_ACK) begin
            if (cur_i.remaining != 8'd0) begin
              act = (cur_i.remaining > 8'd1) ? i2cmts_pkg::ACT_RXACK
                                             : i2cmts_pkg::ACT_RXNACK;
              nxt.phase = i2cmts_pkg::PH_RX;
            end else begin
              fin = 1'b1; fin_ok = 1'b1; act = i2cmts_pkg::ACT_STOP;
            end
          end else if (st == i2cmts_pkg::ST_SLAR_NACK) begin
            fin = 1'b1; fin_ok = 1'b1; act = i2cmts_pkg::ACT_STOP;
          end else if (st == i2cmts_pkg::ST_ARB_LOST) begin
            act = i2cmts_pkg::ACT_START; nxt.phase = i2cmts_pkg::PH_START;
          end else begin
            fin = 1'b1; act = i2cmts_pkg::ACT_STOP;
          end
        end
        i2cmts_pkg::PH_RX: begin
          if (st inside {i2cmts_pkg::ST_RX_ACK, i2cmts_pkg::ST_RX_NACK}) begin
            res.read_valid  = 1'b1;
            res.read_byte   = item_i.rx_byte;
            nxt.transferred = cur_i.transferred + 8'd1;
            nxt.remaining   = (st == i2cmts_pkg::ST_RX_NACK || cur_i.remaining == 8'd0) ?
                              8'd0 : cur_i.remaining - 8'd1;
            if (nxt.remaining == 8'd0) begin
              fin = 1'b1; fin_ok = 1'b1; act = i2cmts_pkg::ACT_STOP;
            end else begin
              act = (nxt.remaining > 8'd1) ? i2cmts_pkg::ACT_RXACK
                                           : i2cmts_pkg::ACT_RXNACK;
              nxt.phase = i2cmts_pkg::PH_RX;
            end
          end else begin
            fin = 1'b1; act = i2cmts_pkg::ACT_STOP;
          end
        end
        i2cmts_pkg::PH_TX: begin
          if (st == i2cmts_pkg::ST_DATA_ACK) begin
            nxt.transferred = cur_i.transferred + 8'd1;
            nxt.remaining   = (cur_i.remaining == 8'd0) ? 8'd0 : cur_i.remaining - 8'd1;
            if (nxt.remaining != 8'd0) begin
              act = i2cmts_pkg::ACT_SEND; tx = item_i.write_byte;
              nxt.phase = i2cmts_pkg::PH_TX;
            end else begin
              fin = 1'b1; fin_ok = 1'b1; act = i2cmts_pkg::ACT_STOP;
            end
          end else begin
            fin = 1'b1; act = i2cmts_pkg::ACT_STOP;
          end
        end
        default: begin
          nxt.phase = i2cmts_pkg::PH_IDLE;
        end
      endcase
    end

    res.action  = act;
    res.tx_byte = (act == i2cmts_pkg::ACT_SEND) ? tx : 8'd0;
    if (fin) begin
      nxt.phase      = i2cmts_pkg::PH_IDLE;
      res.done_res   = 1'b1;
      res.failed     = ~fin_ok;
      res.byte_count = fin_ok ? nxt.transferred : 8'd0;
    end
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule

// ===== sv/i2cmts_checker.sv =====
// port-level checks for the sequencer, bound to the top level
module i2cmts_assertions (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input i2cmts_pkg::res_t res_data_i
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result changed while stalled");

  // a finished transaction issues no bus action other than a stop in the same item
  a_done_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.done_res |->
      res_data_i.action == i2cmts_pkg::ACT_NONE ||
      res_data_i.action == i2cmts_pkg::ACT_STOP)
    else $error("done with a bus action other than none or stop");

  // failure and count only come with completion, and never together
  a_fail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.failed || res_data_i.byte_count != 8'd0) |->
      res_data_i.done_res && !(res_data_i.failed && res_data_i.byte_count != 8'd0))
    else $error("failed or byte count without a clean completion");

  // a received byte goes with receiving again or stopping
  a_rx_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.read_valid |->
      res_data_i.action == i2cmts_pkg::ACT_RXACK ||
      res_data_i.action == i2cmts_pkg::ACT_RXNACK ||
      res_data_i.action == i2cmts_pkg::ACT_STOP)
    else $error("read byte with an unexpected action");

endmodule

bind i2c_master_transaction_sequencer i2cmts_assertions u_i2cmts_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

// ===== tb/sv/i2cmts_checker.sv =====
// checker for the i2c master transaction sequencer: predicts and compares results
module i2cmts_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  i2cmts_req_if      req_i,
  i2cmts_res_if      res_i,
  output int         pending_o,
  output int         errors_o
);
  import i2cmts_pkg::*;

  // shadow of the sequencer state
  phase_e      seq_phase;
  logic [4:0]  max_attempts;
  logic [4:0]  attempts;
  logic [7:0]  left;
  logic [7:0]  moved;
  logic [7:0]  dev;
  logic [15:0] addr;
  logic [1:0]  flags;

  res_t        bus_actions_q[$];
  res_t        want;
  int          mismatches = 0;
  int          queued = 0;

  assign pending_o = queued;
  assign errors_o  = mismatches;

  function automatic res_t finish_with(logic ok, action_e act);
    res_t o;
    o            = '0;
    o.action     = act;
    o.done_res   = 1'b1;
    o.failed     = ~ok;
    o.byte_count = ok ? moved : 8'd0;
    seq_phase    = PH_IDLE;
    return o;
  endfunction

  function automatic res_t send_byte(logic [7:0] b, phase_e nxt);
    res_t o;
    o         = '0;
    o.action  = ACT_SEND;
    o.tx_byte = b;
    seq_phase = nxt;
    return o;
  endfunction

  function automatic res_t restart();
    res_t o;
    o         = '0;
    o.action  = ACT_START;
    seq_phase = PH_START;
    return o;
  endfunction

  function automatic res_t receive_next();
    res_t o;
    o         = '0;
    o.action  = (left > 8'd1) ? ACT_RXACK : ACT_RXNACK;
    seq_phase = PH_RX;
    return o;
  endfunction

  function automatic res_t predict_bus_action(req_t r);
    res_t       o;
    logic [7:0] st;
    logic       rd;
    o  = '0;
    st = r.bus_status & ST_MASK;
    rd = flags[FLAG_READ];
    if (r.req_type == REQ_START) begin
      flags    = {r.two_byte_addr, r.is_read};
      dev      = r.dev_addr;
      addr     = r.mem_addr;
      left     = (r.length > MAX_LENGTH) ? MAX_LENGTH : r.length;
      moved    = '0;
      attempts = '0;
      if (attempts >= max_attempts) begin
        o = finish_with(1'b0, ACT_NONE);
      end else begin
        attempts = 5'd1;
        o = restart();
      end
    end else begin
      case (seq_phase)
        PH_START: begin
          if (st == ST_START || st == ST_REP_START) o = send_byte(dev, PH_SLAW);
          else if (st == ST_ARB_LOST) o = restart();
          else o = finish_with(1'b0, ACT_NONE);
        end
        PH_SLAW: begin
          if (st == ST_SLAW_ACK) begin
            if (flags[FLAG_TWO_B]) o = send_byte(addr[15:8], PH_ADDRHI);
            else o = send_byte(addr[7:0], PH_ADDRLO);
          end else if (st == ST_SLAW_NACK) begin
            if (attempts >= max_attempts) begin
              o = finish_with(1'b0, ACT_NONE);
            end else begin
              attempts = attempts + 5'd1;
              o = restart();
            end
          end else if (st == ST_ARB_LOST) begin
            o = restart();
          end else begin
            o = finish_with(1'b0, ACT_STOP);
          end
        end
        PH_ADDRHI, PH_ADDRLO: begin
          if (st == ST_DATA_ACK) begin
            if (seq_phase == PH_ADDRHI) begin
              o = send_byte(addr[7:0], PH_ADDRLO);
            end else if (rd) begin
              o.action  = ACT_START;
              seq_phase = PH_RESTART;
            end else if (left != 8'd0) begin
              o = send_byte(r.write_byte, PH_TX);
            end else begin
              o = finish_with(1'b1, ACT_STOP);
            end
          end else if (st == ST_DATA_NACK) begin
            o = finish_with(1'b1, ACT_STOP);
          end else if (st == ST_ARB_LOST) begin
            o = restart();
          end else begin
            o = finish_with(1'b0, ACT_STOP);
          end
        end
        PH_RESTART: begin
          if (st == ST_START || st == ST_REP_START) o = send_byte({dev[7:1], 1'b1}, PH_SLAR);
          else if (st == ST_ARB_LOST) o = restart();
          else o = finish_with(1'b0, ACT_STOP);
        end
        PH_SLAR: begin
          if (st == ST_SLAR_ACK) begin
            if (left != 8'd0) o = receive_next();
            else o = finish_with(1'b1, ACT_STOP);
          end else if (st == ST_SLAR_NACK) begin
            o = finish_with(1'b1, ACT_STOP);
          end else if (st == ST_ARB_LOST) begin
            o = restart();
          end else begin
            o = finish_with(1'b0, ACT_STOP);
          end
        end
        PH_RX: begin
          if (st == ST_RX_ACK || st == ST_RX_NACK) begin
            moved = moved + 8'd1;
            left  = (st == ST_RX_NACK || left == 8'd0) ? 8'd0 : left - 8'd1;
            if (left == 8'd0) o = finish_with(1'b1, ACT_STOP);
            else o = receive_next();
            o.read_valid = 1'b1;
            o.read_byte  = r.rx_byte;
          end else begin
            o = finish_with(1'b0, ACT_STOP);
          end
        end
        PH_TX: begin
          if (st == ST_DATA_ACK) begin
            moved = moved + 8'd1;
            left  = (left == 8'd0) ? 8'd0 : left - 8'd1;
            if (left != 8'd0) o = send_byte(r.write_byte, PH_TX);
            else o = finish_with(1'b1, ACT_STOP);
          end else begin
            o = finish_with(1'b0, ACT_STOP);
          end
        end
        default: seq_phase = PH_IDLE;
      endcase
    end
    return o;
  endfunction

  function automatic void flag_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
    $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, exp_v, got_v);
    mismatches++;
  endfunction

  function automatic void compare_result(res_t exp_r, res_t got);
    if (got.action !== exp_r.action)
      flag_field("action", 8'(exp_r.action), 8'(got.action));
    if (got.tx_byte !== exp_r.tx_byte) flag_field("tx_byte", exp_r.tx_byte, got.tx_byte);
    if (got.read_valid !== exp_r.read_valid)
      flag_field("read_valid", 8'(exp_r.read_valid), 8'(got.read_valid));
    if (got.read_byte !== exp_r.read_byte)
      flag_field("read_byte", exp_r.read_byte, got.read_byte);
    if (got.done_res !== exp_r.done_res)
      flag_field("done_res", 8'(exp_r.done_res), 8'(got.done_res));
    if (got.failed !== exp_r.failed)
      flag_field("failed", 8'(exp_r.failed), 8'(got.failed));
    if (got.byte_count !== exp_r.byte_count)
      flag_field("byte_count", exp_r.byte_count, got.byte_count);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_phase    = PH_IDLE;
      max_attempts = MAX_ATTEMPTS_RST;
      attempts     = '0;
      left         = '0;
      moved        = '0;
      dev          = '0;
      addr         = '0;
      flags        = '0;
      bus_actions_q.delete();
      queued <= 0;
    end else begin
      if (cfg_we_i) max_attempts = cfg_wdata_i;
      // compare before pushing so a stray result never meets this edge's item
      if (res_i.valid && res_i.ready) begin
        if (bus_actions_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %0h", $time, res_i.data);
          mismatches++;
        end else begin
          want = bus_actions_q.pop_front();
          compare_result(want, res_i.data);
        end
      end
      if (req_i.valid && req_i.ready) bus_actions_q.push_back(predict_bus_action(req_i.data));
      queued <= bus_actions_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_i2c_master_transaction_sequencer.sv =====
// testbench top for the i2c master transaction sequencer: stimulus and verdict
module tb_i2c_master_transaction_sequencer;
  import i2cmts_pkg::*;

  // cycles with no item moving on either channel before the run is called hung
  localparam int STALL_LIMIT = 2000;
  localparam int GAP_MAX     = 12;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [4:0] cfg_wdata_i = '0;

  i2cmts_req_if req_if ();
  i2cmts_res_if res_if ();

  int         pending;
  int         errors;
  int         items_sent = 0;
  // quiet stretches: no gaps from the sender or no stalls from the receiver
  logic       tx_quiet = 1'b0;
  logic       rx_quiet = 1'b0;
  // our own copy of the retry limit, used only to shape the bus script
  logic [4:0] attempt_limit = MAX_ATTEMPTS_RST;

  i2c_master_transaction_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  i2cmts_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_i       (res_if),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // 8 unit clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // fully random item, every field and bit free
  function automatic req_t noise_req();
    logic [63:0] n;
    n = {$urandom(), $urandom()};
    return n[$bits(req_t)-1:0];
  endfunction

  // start item; the event-only fields carry random junk the block must ignore
  function automatic req_t start_of(logic rd, logic two, logic [7:0] dev_a,
                                    logic [15:0] mem_a, logic [7:0] len);
    req_t r;
    r               = noise_req();
    r.req_type      = REQ_START;
    r.is_read       = rd;
    r.two_byte_addr = two;
    r.dev_addr      = dev_a;
    r.mem_addr      = mem_a;
    r.length        = len;
    return r;
  endfunction

  // status event; start-only fields are random junk
  function automatic req_t event_of(logic [7:0] st, logic [7:0] rx, logic [7:0] wb);
    req_t r;
    r            = noise_req();
    r.req_type   = REQ_EVENT;
    r.bus_status = st;
    r.rx_byte    = rx;
    r.write_byte = wb;
    return r;
  endfunction

  // offer one item after a random gap, return at the edge where it is taken
  task automatic send_req(input req_t r);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  // sender holds off until every predicted result has been taken
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // retry limit may only change while the sequencer has nothing in flight
  task automatic set_attempt_limit(input logic [4:0] v);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= v;
    attempt_limit  = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one transaction played as a well-behaved bus engine would report it,
  // with an occasional fault: lost arbitration, a nack, or a junk status
  task automatic run_transfer();
    req_t       r;
    phase_e     bus_at;
    logic [7:0] left;
    logic [7:0] code;
    logic       rd;
    logic       two;
    int         tries;
    int         events;
    int         pick;
    r      = noise_req();
    rd     = r.is_read;
    two    = r.two_byte_addr;
    pick   = $urandom_range(0, 99);
    // mostly short transfers, now and then the longest one
    if (pick < 10)      left = 8'd0;
    else if (pick < 85) left = 8'($urandom_range(1, 4));
    else if (pick < 97) left = 8'($urandom_range(5, 20));
    else if (pick < 99) left = 8'($urandom_range(21, 254));
    else                left = MAX_LENGTH;
    send_req(start_of(rd, two, r.dev_addr, r.mem_addr, left));
    bus_at = (attempt_limit == 5'd0) ? PH_IDLE : PH_START;
    tries  = 1;
    events = 0;
    while (bus_at != PH_IDLE && events < 400) begin
      case (bus_at)
        PH_START, PH_RESTART: code = $urandom_range(0, 1) ? ST_START : ST_REP_START;
        PH_SLAW:              code = ST_SLAW_ACK;
        PH_SLAR:              code = ST_SLAR_ACK;
        PH_RX:                code = (left > 8'd1) ? ST_RX_ACK : ST_RX_NACK;
        default:              code = ST_DATA_ACK;
      endcase
      if ($urandom_range(0, 99) < 9) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          code = ST_ARB_LOST;
        end else if (pick == 1) begin
          case (bus_at)
            PH_SLAW: code = ST_SLAW_NACK;
            PH_SLAR: code = ST_SLAR_NACK;
            PH_RX:   code = ST_RX_NACK;
            PH_START, PH_RESTART: code = ST_SLAR_ACK;
            default: code = ST_DATA_NACK;
          endcase
        end else begin
          code = 8'($urandom_range(0, 255)) & ST_MASK;
        end
      end
      send_req(event_of(code | 8'($urandom_range(0, 7)), 8'($urandom), 8'($urandom)));
      events++;
      // follow the script; any fault that ends the transfer drops to idle
      case (bus_at)
        PH_START, PH_RESTART: begin
          if (code == ST_START || code == ST_REP_START)
            bus_at = (bus_at == PH_START) ? PH_SLAW : PH_SLAR;
          else if (code == ST_ARB_LOST) bus_at = PH_START;
          else bus_at = PH_IDLE;
        end
        PH_SLAW: begin
          if (code == ST_SLAW_ACK) begin
            bus_at = two ? PH_ADDRHI : PH_ADDRLO;
          end else if (code == ST_SLAW_NACK) begin
            if (tries >= int'(attempt_limit)) begin
              bus_at = PH_IDLE;
            end else begin
              tries++;
              bus_at = PH_START;
            end
          end else if (code == ST_ARB_LOST) begin
            bus_at = PH_START;
          end else begin
            bus_at = PH_IDLE;
          end
        end
        PH_ADDRHI: begin
          if (code == ST_DATA_ACK) bus_at = PH_ADDRLO;
          else if (code == ST_ARB_LOST) bus_at = PH_START;
          else bus_at = PH_IDLE;
        end
        PH_ADDRLO: begin
          if (code == ST_DATA_ACK) bus_at = rd ? PH_RESTART : (left != 8'd0 ? PH_TX : PH_IDLE);
          else if (code == ST_ARB_LOST) bus_at = PH_START;
          else bus_at = PH_IDLE;
        end
        PH_SLAR: begin
          if (code == ST_SLAR_ACK) bus_at = (left != 8'd0) ? PH_RX : PH_IDLE;
          else if (code == ST_ARB_LOST) bus_at = PH_START;
          else bus_at = PH_IDLE;
        end
        PH_RX: begin
          left = left - 8'd1;
          if (code != ST_RX_ACK || left == 8'd0) bus_at = PH_IDLE;
        end
        default: begin
          left = left - 8'd1;
          if (code != ST_DATA_ACK || left == 8'd0) bus_at = PH_IDLE;
        end
      endcase
    end
    // sometimes a stray status shows up after the transfer has closed
    if ($urandom_range(0, 9) == 0)
      send_req(event_of(8'($urandom_range(0, 255)), 8'($urandom), 8'($urandom)));
  endtask

  // result side: random stall before each result, none in quiet stretches
  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // watchdog: a hang shows up as a long run of cycles with nothing moving
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int seg;
    int target;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, retry limit still at its reset value
    // status event while idle does nothing
    send_req(event_of(ST_START, 8'hFF, 8'hFF));
    // one-byte write with the status low bits set, must be masked off
    send_req(start_of(1'b0, 1'b0, 8'hA0, 16'h0012, 8'd1));
    send_req(event_of(ST_START | ~ST_MASK, 8'h00, 8'h00));
    send_req(event_of(ST_SLAW_ACK, 8'h00, 8'h00));
    send_req(event_of(ST_DATA_ACK, 8'h00, 8'hFF));
    send_req(event_of(ST_DATA_ACK, 8'h00, 8'h00));
    // read at the top of the field ranges, lost arbitration at the start,
    // then an early nack on the data closes it with two bytes moved
    send_req(start_of(1'b1, 1'b1, 8'hFF, 16'hFFFF, 8'hFF));
    send_req(event_of(ST_ARB_LOST, 8'h00, 8'h00));
    send_req(event_of(ST_REP_START, 8'h00, 8'h00));
    send_req(event_of(ST_SLAW_ACK, 8'h00, 8'h00));
    send_req(event_of(ST_DATA_ACK, 8'h00, 8'h00));
    send_req(event_of(ST_DATA_ACK, 8'h00, 8'h00));
    send_req(event_of(ST_START, 8'h00, 8'h00));
    send_req(event_of(ST_SLAR_ACK, 8'h00, 8'h00));
    send_req(event_of(ST_RX_ACK, 8'hFF, 8'h00));
    send_req(event_of(ST_RX_NACK, 8'h00, 8'hFF));
    // zero-length read at the bottom of the ranges with one address nack retry
    send_req(start_of(1'b1, 1'b0, 8'h00, 16'h0000, 8'h00));
    send_req(event_of(ST_START, 8'h00, 8'h00));
    send_req(event_of(ST_SLAW_NACK, 8'h00, 8'h00));
    send_req(event_of(ST_START, 8'h00, 8'h00));
    send_req(event_of(ST_SLAW_ACK, 8'h00, 8'h00));
    send_req(event_of(ST_DATA_ACK, 8'h00, 8'h00));
    // new start while the read is still going drops it without a stop
    send_req(start_of(1'b0, 1'b1, 8'h5A, 16'hA55A, 8'd3));
    // junk status right after the start fails the transfer
    send_req(event_of(~ST_MASK, 8'h00, 8'h00));
    send_req(event_of(ST_START, 8'h00, 8'h00));

    // random part in segments, each sets a retry limit and an idling style;
    // the drain in front of every segment doubles as the sender holding off
    for (seg = 0; seg < 6; seg++) begin
      drain();
      case (seg)
        0:       set_attempt_limit(5'd1);
        1:       set_attempt_limit(5'd31);
        2:       set_attempt_limit(5'd0);
        3:       set_attempt_limit(5'($urandom_range(2, 5)));
        4:       set_attempt_limit(MAX_ATTEMPTS_RST);
        default: set_attempt_limit(5'($urandom_range(1, 31)));
      endcase
      tx_quiet = (seg == 1 || seg == 3);
      rx_quiet = (seg == 2 || seg == 3);
      target   = items_sent + ((seg == 2) ? 80 : 220);
      while (items_sent < target) begin
        if ($urandom_range(0, 19) == 0) begin
          repeat ($urandom_range(1, 3)) send_req(noise_req());
        end else begin
          run_transfer();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/i2cmts_pkg.sv
sv/i2cmts_req_if.sv
sv/i2cmts_res_if.sv
sv/i2cmts_step.sv
sv/i2c_master_transaction_sequencer.sv
sv/i2cmts_checker.sv
tb/sv/i2cmts_checker.sv
tb/sv/tb_i2c_master_transaction_sequencer.sv
